/* sv/ausp_pkg.sv */
package ausp_pkg;

   localparam int unsigned DATA_W = 8;
   localparam int unsigned WORD_W = 32;
   localparam int unsigned SAMPLE_W = 16;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CNT_W = 5;

   localparam logic [WORD_W-1:0] MAGIC_RESET = 32'h2E73_6E64;
   localparam logic [WORD_W-1:0] ENCODING_RESET = 32'd3;
   localparam logic [WORD_W-1:0] RATE_RESET = 32'd8000;
   localparam logic [WORD_W-1:0] CHANNELS_RESET = 32'd1;
   localparam logic [WORD_W-1:0] MIN_OFFSET = 32'd24;

   localparam logic [CSR_IDX_W-1:0] CSR_MAGIC = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ENCODING = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RATE = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNELS = 2'd3;

   localparam logic [2:0] WORD_MAGIC = 3'd1;
   localparam logic [2:0] WORD_OFFSET = 3'd2;
   localparam logic [2:0] WORD_SIZE = 3'd3;
   localparam logic [2:0] WORD_ENCODING = 3'd4;
   localparam logic [2:0] WORD_RATE = 3'd5;

   typedef enum logic [1:0] {
      PH_WAIT,
      PH_HEADER,
      PH_SKIP,
      PH_DATA
   } phase_type;

   typedef enum logic [1:0] {
      KIND_SAMPLE,
      KIND_HEADER,
      KIND_ERROR
   } kind_type;

   typedef enum logic [2:0] {
      ERR_MAGIC,
      ERR_OFFSET,
      ERR_ENCODING,
      ERR_RATE,
      ERR_CHANNELS,
      ERR_TRUNC_SAMPLE,
      ERR_TRUNC_HEADER
   } err_type;

   typedef struct packed {
      logic [WORD_W-1:0] magic;
      logic [WORD_W-1:0] encoding;
      logic [WORD_W-1:0] rate;
      logic [WORD_W-1:0] channels;
   } cfg_type;

   typedef struct packed {
      logic                         has_result;
      kind_type                     kind;
      logic signed [SAMPLE_W-1:0]   sample;
      err_type                      err;
      logic [WORD_W-1:0]            size;
      logic [WORD_W-1:0]            offset;
   } result_type;

endpackage

/* sv/ausp_if.sv */
interface ausp_req_if;
   logic                          valid;
   logic                          ready;
   logic [ausp_pkg::DATA_W-1:0]   data_byte;
   logic                          first_byte_of_file;
   logic                          last_byte_of_file;

   modport source (output valid, output data_byte, output first_byte_of_file,
                   output last_byte_of_file, input ready);
   modport sink (input valid, input data_byte, input first_byte_of_file,
                 input last_byte_of_file, output ready);
endinterface

interface ausp_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [1:0]                           result_kind;
   logic signed [ausp_pkg::SAMPLE_W-1:0] sample_value;
   logic [2:0]                           error_code;
   logic [ausp_pkg::WORD_W-1:0]          header_data_size;
   logic [ausp_pkg::WORD_W-1:0]          header_data_offset;

   modport source (output valid, output result_kind, output sample_value,
                   output error_code, output header_data_size,
                   output header_data_offset, input ready);
   modport sink (input valid, input result_kind, input sample_value,
                 input error_code, input header_data_size,
                 input header_data_offset, output ready);
endinterface

/* sv/ausp_parser.sv */
module ausp_parser (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic [ausp_pkg::DATA_W-1:0]   data_byte,
   input  logic                          first,
   input  logic                          last,
   input  ausp_pkg::cfg_type             cfg,
   output ausp_pkg::result_type          res
);

   ausp_pkg::phase_type                 phase_ff, phase_in;
   logic [ausp_pkg::CNT_W-1:0]          cnt_ff, cnt_in;
   logic [ausp_pkg::WORD_W-1:0]         shift_ff, shift_in;
   logic [ausp_pkg::WORD_W-1:0]         offset_ff, offset_in;
   logic [ausp_pkg::WORD_W-1:0]         size_ff, size_in;
   logic [ausp_pkg::WORD_W-1:0]         skip_ff, skip_in;
   logic [ausp_pkg::DATA_W-1:0]         hold_ff, hold_in;
   logic                                half_ff, half_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= ausp_pkg::PH_WAIT;
         cnt_ff <= '0;
         shift_ff <= '0;
         offset_ff <= '0;
         size_ff <= '0;
         skip_ff <= '0;
         hold_ff <= '0;
         half_ff <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in;
         cnt_ff <= cnt_in;
         shift_ff <= shift_in;
         offset_ff <= offset_in;
         size_ff <= size_in;
         skip_ff <= skip_in;
         hold_ff <= hold_in;
         half_ff <= half_in;
      end
   end

   always_comb begin
      ausp_pkg::phase_type ph;
      logic fail;
      logic hdr_done;
      ausp_pkg::err_type code;

      ph = first ? ausp_pkg::PH_HEADER : phase_ff;
      fail = 1'b0;
      hdr_done = 1'b0;
      code = ausp_pkg::ERR_MAGIC;
      phase_in = ph;
      cnt_in = first ? '0 : cnt_ff;
      shift_in = first ? '0 : shift_ff;
      half_in = first ? 1'b0 : half_ff;
      offset_in = offset_ff;
      size_in = size_ff;
      skip_in = skip_ff;
      hold_in = hold_ff;
      res = '0;

      unique case (ph)
         ausp_pkg::PH_HEADER: begin
            shift_in = {shift_in[ausp_pkg::WORD_W-ausp_pkg::DATA_W-1:0], data_byte};
            cnt_in = cnt_in + 5'd1;
            if (cnt_in[1:0] == 2'b00) begin
               case (cnt_in[4:2])
                  ausp_pkg::WORD_MAGIC: begin
                     if (shift_in != cfg.magic) begin
                        fail = 1'b1;
                        code = ausp_pkg::ERR_MAGIC;
                     end
                  end
                  ausp_pkg::WORD_OFFSET: begin
                     offset_in = shift_in;
                     if (shift_in < ausp_pkg::MIN_OFFSET) begin
                        fail = 1'b1;
                        code = ausp_pkg::ERR_OFFSET;
                     end
                  end
                  ausp_pkg::WORD_SIZE: begin
                     size_in = shift_in;
                  end
                  ausp_pkg::WORD_ENCODING: begin
                     if (shift_in != cfg.encoding) begin
                        fail = 1'b1;
                        code = ausp_pkg::ERR_ENCODING;
                     end
                  end
                  ausp_pkg::WORD_RATE: begin
                     if (shift_in != cfg.rate) begin
                        fail = 1'b1;
                        code = ausp_pkg::ERR_RATE;
                     end
                  end
                  default: begin
                     if (shift_in != cfg.channels) begin
                        fail = 1'b1;
                        code = ausp_pkg::ERR_CHANNELS;
                     end else begin
                        hdr_done = 1'b1;
                     end
                  end
               endcase
            end
            if (hdr_done) begin
               skip_in = offset_ff - ausp_pkg::MIN_OFFSET;
               half_in = 1'b0;
               if (last) begin
                  phase_in = ausp_pkg::PH_WAIT;
               end else if (skip_in != '0) begin
                  phase_in = ausp_pkg::PH_SKIP;
               end else begin
                  phase_in = ausp_pkg::PH_DATA;
               end
               res.has_result = 1'b1;
               res.kind = ausp_pkg::KIND_HEADER;
               res.size = size_ff;
               res.offset = offset_ff;
            end else if (fail || last) begin
               phase_in = ausp_pkg::PH_WAIT;
               res.has_result = 1'b1;
               res.kind = ausp_pkg::KIND_ERROR;
               res.err = fail ? code : ausp_pkg::ERR_TRUNC_HEADER;
            end
         end
         ausp_pkg::PH_SKIP: begin
            skip_in = skip_ff - 32'd1;
            if (last) begin
               phase_in = ausp_pkg::PH_WAIT;
            end else if (skip_in == '0) begin
               phase_in = ausp_pkg::PH_DATA;
            end
         end
         ausp_pkg::PH_DATA: begin
            if (!half_in) begin
               hold_in = data_byte;
               half_in = 1'b1;
               if (last) begin
                  phase_in = ausp_pkg::PH_WAIT;
                  res.has_result = 1'b1;
                  res.kind = ausp_pkg::KIND_ERROR;
                  res.err = ausp_pkg::ERR_TRUNC_SAMPLE;
               end
            end else begin
               half_in = 1'b0;
               if (last) begin
                  phase_in = ausp_pkg::PH_WAIT;
               end
               res.has_result = 1'b1;
               res.kind = ausp_pkg::KIND_SAMPLE;
               res.sample = {hold_ff, data_byte};
            end
         end
         default: begin
         end
      endcase
   end

endmodule

/* sv/au_stream_header_and_sample_parser_top.sv */
// Each accepted request is captured in the input register; any result it yields is registered in the result register.
// Throughput: one request per cycle while the result is not stalled; a stalled result holds the input register.
// Each byte is parsed by a single pass of logic between input and result registers.
// Reset (synchronous, active high) returns the parser to waiting for a first-marked
// byte, empties both registers and restores the configuration reset values.
module au_stream_header_and_sample_parser_top (
   input  logic                              clock,
   input  logic                              reset,
   ausp_req_if.sink                          req_ch,
   ausp_rsp_if.source                        rsp_ch,
   input  logic                              csr_write_enable,
   input  logic [ausp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ausp_pkg::WORD_W-1:0]       csr_write_data
);

   ausp_pkg::cfg_type                 cfg_ff;
   logic                              in_valid_ff;
   logic [ausp_pkg::DATA_W-1:0]       in_byte_ff;
   logic                              in_first_ff;
   logic                              in_last_ff;
   logic                              advance;
   ausp_pkg::result_type              res;
   logic                              out_valid_ff;
   ausp_pkg::result_type              out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.magic <= ausp_pkg::MAGIC_RESET;
         cfg_ff.encoding <= ausp_pkg::ENCODING_RESET;
         cfg_ff.rate <= ausp_pkg::RATE_RESET;
         cfg_ff.channels <= ausp_pkg::CHANNELS_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            ausp_pkg::CSR_MAGIC: cfg_ff.magic <= csr_write_data;
            ausp_pkg::CSR_ENCODING: cfg_ff.encoding <= csr_write_data;
            ausp_pkg::CSR_RATE: cfg_ff.rate <= csr_write_data;
            ausp_pkg::CSR_CHANNELS: cfg_ff.channels <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   assign advance = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_byte_ff <= req_ch.data_byte;
         in_first_ff <= req_ch.first_byte_of_file;
         in_last_ff <= req_ch.last_byte_of_file;
      end
   end

   ausp_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .data_byte (in_byte_ff),
      .first     (in_first_ff),
      .last      (in_last_ff),
      .cfg       (cfg_ff),
      .res       (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= res.has_result;
      end else if (rsp_ch.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && res.has_result) begin
         out_ff <= res;
      end
   end

   assign rsp_ch.valid = out_valid_ff;
   assign rsp_ch.result_kind = out_ff.kind;
   assign rsp_ch.sample_value = out_ff.sample;
   assign rsp_ch.error_code = out_ff.err;
   assign rsp_ch.header_data_size = out_ff.size;
   assign rsp_ch.header_data_offset = out_ff.offset;

endmodule
